// File: hw/rtl/hwc_pkg.sv
`timescale 1ns / 1ps

package hwc_pkg;

	// Field widths
	localparam int unsigned SIZE_W    = 13;
	localparam int unsigned IDX_W     = 12;
	localparam int unsigned COEF_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Largest window that is accepted as valid.
	localparam int unsigned MAX_WINDOW = 4096;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE = 2'd1;

	// Reset values of the registers.
	localparam logic [SIZE_W-1:0] SIZE_RESET   = 13'd256;
	localparam logic [SIZE_W-1:0] CENTRE_RESET = 13'h1FFF;

	// Queue between the front and the back.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Number of quotient bits produced by the divider, one per stage.
	localparam int unsigned DIV_STEPS = 30;

	// Polynomial coefficients for sin(pi/2 * x), all Q30.
	localparam logic [30:0] COEF_A1 = 31'd1686629704;
	localparam logic [29:0] COEF_B3 = 30'd693598254;
	localparam logic [29:0] COEF_A5 = 30'd85566142;
	localparam logic [29:0] COEF_B7 = 30'd5018418;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	// Rounding term for Q60 to Q15, and 1.0 in Q1.15.
	localparam logic [62:0] ROUND_Q15 = 63'd17592186044416;
	localparam logic [COEF_W-1:0] Q15_ONE = 16'h8000;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		logic              err;
		logic              peak;
		logic [IDX_W-1:0]  j;
		logic [SIZE_W-1:0] len;
	} hwc_item_t;

	// Queue status seen by the top level.
	typedef struct packed {
		logic full;
		logic empty;
	} hwc_qstat_t;

endpackage

// File: hw/rtl/hwc_front.sv
`timescale 1ns / 1ps

module hwc_front (
	input  logic [hwc_pkg::SIZE_W-1:0] window_size,
	input  logic [hwc_pkg::SIZE_W-1:0] window_centre,
	input  logic [hwc_pkg::IDX_W-1:0]  sample_index,
	output hwc_pkg::hwc_item_t         item
);
	import hwc_pkg::*;

	logic              centre_neg;
	logic [IDX_W-1:0]  c;
	logic [SIZE_W-1:0] idx_ext;
	logic [SIZE_W-1:0] c_ext;
	logic [SIZE_W-1:0] last;
	logic [SIZE_W-1:0] half;
	logic [SIZE_W-1:0] mirror;
	logic [SIZE_W-1:0] right_span;
	logic              size_bad;
	logic              centre_bad;
	logic              idx_bad;
	logic              left;
	logic              peak;
	logic [SIZE_W-1:0] len;

	assign centre_neg = window_centre[SIZE_W-1];
	assign c          = window_centre[IDX_W-1:0];
	assign idx_ext    = {1'b0, sample_index};
	assign c_ext      = {1'b0, c};
	assign last       = window_size - 13'd1;
	assign half       = window_size >> 1;
	assign mirror     = last - idx_ext;
	assign right_span = last - c_ext;

	// Range checks on the size, the centre and the index.
	assign size_bad   = (window_size == '0) || (32'(window_size) > MAX_WINDOW);
	assign centre_bad = !centre_neg && (c_ext >= window_size);
	assign idx_bad    = idx_ext >= window_size;

	// Side of the peak, peak detection and effective length per mode.
	always_comb begin
		if (centre_neg) begin
			peak = window_size[0] && (idx_ext == half);
			left = idx_ext < half;
			len  = window_size;
		end else begin
			peak = sample_index == c;
			left = sample_index < c;
			len  = left ? {c, 1'b1} : {right_span[IDX_W-1:0], 1'b1};
		end
	end

	assign item.err  = size_bad || centre_bad || idx_bad;
	assign item.peak = peak;
	assign item.j    = left ? sample_index : mirror[IDX_W-1:0];
	assign item.len  = len;

endmodule

// File: hw/rtl/hwc_queue.sv
`timescale 1ns / 1ps

module hwc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hwc_pkg::hwc_item_t push_item,
	input  logic               pop,
	output hwc_pkg::hwc_item_t head,
	output hwc_pkg::hwc_qstat_t stat
);
	import hwc_pkg::*;

	hwc_item_t          slot_q [0:QDEPTH-1];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = count_q == QCNT_W'(QDEPTH);
	assign stat.empty = count_q == '0;

endmodule

// File: hw/rtl/hwc_back.sv
`timescale 1ns / 1ps

module hwc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  hwc_pkg::hwc_item_t         in_item,
	output logic                       out_valid,
	output logic [hwc_pkg::COEF_W-1:0] coefficient,
	output logic                       range_error
);
	import hwc_pkg::*;

	// Divider pipeline: stage 0 loads 2j+1, each later stage makes one quotient bit.
	logic [SIZE_W-1:0]    div_rem_s  [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] div_quo_s  [0:DIV_STEPS];
	logic [SIZE_W-1:0]    div_len_s  [0:DIV_STEPS];
	logic                 div_err_s  [0:DIV_STEPS];
	logic                 div_peak_s [0:DIV_STEPS];
	logic                 div_vld_s  [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_rem_s[0]  <= {in_item.j, 1'b1};
			div_quo_s[0]  <= '0;
			div_len_s[0]  <= in_item.len;
			div_err_s[0]  <= in_item.err;
			div_peak_s[0] <= in_item.peak;
		end
	end

	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
		logic [SIZE_W:0] dbl;
		logic [SIZE_W:0] diff;
		logic            ge;

		assign dbl  = {div_rem_s[i-1], 1'b0};
		assign diff = dbl - {1'b0, div_len_s[i-1]};
		assign ge   = dbl >= {1'b0, div_len_s[i-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i] <= 1'b0;
			end else if (adv) begin
				div_vld_s[i] <= div_vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[i]  <= ge ? diff[SIZE_W-1:0] : dbl[SIZE_W-1:0];
				div_quo_s[i]  <= {div_quo_s[i-1][DIV_STEPS-2:0], ge};
				div_len_s[i]  <= div_len_s[i-1];
				div_err_s[i]  <= div_err_s[i-1];
				div_peak_s[i] <= div_peak_s[i-1];
			end
		end
	end

	// Polynomial pipeline, one multiplier per stage.
	logic [29:0] x;
	logic [59:0] m1;
	logic [59:0] m2;
	logic [59:0] m3;
	logic [59:0] m4;
	logic [60:0] m5;
	logic [61:0] m6;
	logic [62:0] rnd;
	logic [17:0] cv;
	logic [30:0] sv;

	logic [29:0] x_s1, x_s2, x_s3, x_s4;
	logic [29:0] x2_s1, x2_s2, x2_s3;
	logic [29:0] t1_s2, t2_s3;
	logic [30:0] t3_s4;
	logic [30:0] s_s5;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic        err_s1, err_s2, err_s3, err_s4, err_s5;
	logic        peak_s1, peak_s2, peak_s3, peak_s4, peak_s5;
	logic [COEF_W-1:0] coef_s6;
	logic              err_s6;

	assign x   = div_quo_s[DIV_STEPS];
	assign m1  = x * x;
	assign m2  = x2_s1 * COEF_B7;
	assign m3  = x2_s2 * t1_s2;
	assign m4  = x2_s3 * t2_s3;
	assign m5  = x_s4 * t3_s4;
	assign sv  = m5[60:30];
	assign m6  = s_s5 * s_s5;
	assign rnd = {1'b0, m6} + ROUND_Q15;
	assign cv  = rnd[62:45];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= div_vld_s[DIV_STEPS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// x squared
			x_s1    <= x;
			x2_s1   <= m1[59:30];
			err_s1  <= div_err_s[DIV_STEPS];
			peak_s1 <= div_peak_s[DIV_STEPS];
			// Horner steps
			x_s2    <= x_s1;
			x2_s2   <= x2_s1;
			t1_s2   <= COEF_A5 - m2[59:30];
			err_s2  <= err_s1;
			peak_s2 <= peak_s1;
			x_s3    <= x_s2;
			x2_s3   <= x2_s2;
			t2_s3   <= COEF_B3 - m3[59:30];
			err_s3  <= err_s2;
			peak_s3 <= peak_s2;
			x_s4    <= x_s3;
			t3_s4   <= COEF_A1 - {1'b0, m4[59:30]};
			err_s4  <= err_s3;
			peak_s4 <= peak_s3;
			// Sine value, clamped to 1.0
			s_s5    <= (sv > Q30_ONE) ? Q30_ONE : sv;
			err_s5  <= err_s4;
			peak_s5 <= peak_s4;
			// Square, round to Q15 and apply the special cases
			err_s6  <= err_s5;
			if (err_s5) coef_s6 <= '0;
			else if (peak_s5) coef_s6 <= Q15_ONE;
			else if (cv > {2'b0, Q15_ONE}) coef_s6 <= Q15_ONE;
			else coef_s6 <= cv[COEF_W-1:0];
		end
	end

	assign out_valid   = vld_s6;
	assign coefficient = coef_s6;
	assign range_error = err_s6;

endmodule

// File: hw/rtl/hann_window_coefficient_top.sv
`timescale 1ns / 1ps
// Hann window coefficient generator.
// Input channel: sample_index with in_valid / in_stall; a beat is taken at a
// clock edge where in_valid is high and in_stall is low.
// Output channel: coefficient (unsigned Q1.15) and range_error with out_valid /
// out_stall; a beat leaves at an edge where out_valid is high and out_stall low.
// Configuration: cfg_we, cfg_index, cfg_data; register 0 is the window size,
// register 1 the signed centre (negative selects the symmetric window).
// Throughput is one beat per cycle while out_stall is low. A beat passes through
// the input queue register, a 31-stage restoring divider (a load stage, then one
// quotient bit per stage), five multiplier stages and the output register.
// When out_stall is high while out_valid is high the whole back pipeline holds;
// the four-entry queue keeps taking beats until it fills, and then in_stall rises.
// Reset clears the queue and every valid bit and loads a size of 256 and a
// symmetric window.
module hann_window_coefficient_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hwc_pkg::IDX_W-1:0]     sample_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hwc_pkg::COEF_W-1:0]    coefficient,
	output logic                          range_error,
	input  logic                          cfg_we,
	input  logic [hwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hwc_pkg::SIZE_W-1:0]    cfg_data
);
	import hwc_pkg::*;

	logic [SIZE_W-1:0] window_size_q;
	logic [SIZE_W-1:0] window_centre_q;
	hwc_item_t         front_item;
	hwc_item_t         head_item;
	hwc_qstat_t        q_stat;
	logic              push;
	logic              pop;
	logic              adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= SIZE_RESET;
			window_centre_q <= CENTRE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE:   window_size_q   <= cfg_data;
				REG_CENTRE: window_centre_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hwc_front u_front (
		.window_size   (window_size_q),
		.window_centre (window_centre_q),
		.sample_index  (sample_index),
		.item          (front_item)
	);

	// The back advances whenever its output register is free or being taken.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;
	assign pop      = adv && !q_stat.empty;

	hwc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head_item),
		.stat      (q_stat)
	);

	hwc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (!q_stat.empty),
		.in_item     (head_item),
		.out_valid   (out_valid),
		.coefficient (coefficient),
		.range_error (range_error)
	);

	// An error beat always carries a zero coefficient.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> coefficient == '0)
		else $error("error beat with nonzero coefficient");

	// The coefficient never exceeds 1.0.
	a_coef_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> coefficient <= Q15_ONE)
		else $error("coefficient above 1.0");

	// The queue cannot be full and empty at once.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue status inconsistent");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hwc_pkg::*;

	localparam int LATENCY   = 37;
	localparam int CYCLE_CAP = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [IDX_W-1:0]     sample_index;
	logic                 out_valid;
	logic                 out_stall;
	logic [COEF_W-1:0]    coefficient;
	logic                 range_error;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;

	// One expected output beat.
	typedef struct {
		logic [COEF_W-1:0] coef;
		logic              err;
	} coef_beat_t;

	coef_beat_t  pending_coefs[$];
	logic [12:0] win_size;
	logic [12:0] win_centre;
	int          fail_count;
	int          cycle_count;
	int          beats_sent;
	int          beats_checked;
	int          send_idle_pct;
	int          recv_stall_pct;

	hann_window_coefficient_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_index (sample_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.coefficient  (coefficient),
		.range_error  (range_error),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Squared sine of a half Hann step, Q1.15, from the polynomial in Q30.
	function automatic logic [15:0] half_hann_q15(input logic [63:0] j, input logic [63:0] len);
		logic [63:0] x, x2, t, s, c;
		if (len == 0)
			return 16'd0;
		x = ((2 * j + 1) << 30) / len;
		if (x > 64'(Q30_ONE))
			x = 64'(Q30_ONE);
		x2 = (x * x) >> 30;
		t = 64'(COEF_A5) - ((x2 * 64'(COEF_B7)) >> 30);
		t = 64'(COEF_B3) - ((x2 * t) >> 30);
		t = 64'(COEF_A1) - ((x2 * t) >> 30);
		s = (x * t) >> 30;
		if (s > 64'(Q30_ONE))
			s = 64'(Q30_ONE);
		c = (s * s + 64'(ROUND_Q15)) >> 45;
		if (c > 64'h8000)
			c = 64'h8000;
		return c[15:0];
	endfunction

	// Coefficient for one index under the current window setting.
	function automatic coef_beat_t predict_coef(input logic [IDX_W-1:0] idx);
		coef_beat_t  r;
		logic [63:0] size, last, half, cen;
		logic        sym;
		size = 64'(win_size);
		sym  = win_centre[12];
		cen  = 64'(win_centre[11:0]);
		r.err  = 1'b0;
		r.coef = '0;
		if (size == 0 || size > MAX_WINDOW || (!sym && cen >= size) || 64'(idx) >= size) begin
			r.err = 1'b1;
			return r;
		end
		last = size - 1;
		if (sym) begin
			half = size / 2;
			if (size[0] && 64'(idx) == half)
				r.coef = Q15_ONE;
			else if (64'(idx) < half)
				r.coef = half_hann_q15(64'(idx), size);
			else
				r.coef = half_hann_q15(last - 64'(idx), size);
		end else begin
			if (64'(idx) == cen)
				r.coef = Q15_ONE;
			else if (64'(idx) < cen)
				r.coef = half_hann_q15(64'(idx), 2 * cen + 1);
			else
				r.coef = half_hann_q15(last - 64'(idx), 2 * (last - cen) + 1);
		end
		return r;
	endfunction

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Compare each output beat with the oldest expectation.
	always @(posedge clk) begin
		coef_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_coefs.size() == 0) begin
				$error("unexpected beat: coefficient %0d range_error %0b", coefficient,
					range_error);
				fail_count++;
			end else begin
				e = pending_coefs.pop_front();
				beats_checked++;
				if (coefficient !== e.coef) begin
					$error("coefficient: expected %0d, got %0d", e.coef, coefficient);
					fail_count++;
				end
				if (range_error !== e.err) begin
					$error("range_error: expected %0b, got %0b", e.err, range_error);
					fail_count++;
				end
			end
		end
	end

	// Receiver stall, changed at the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Register write while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SIZE)
			win_size = val;
		else if (idx == REG_CENTRE)
			win_centre = val;
	endtask

	// Lower valid, wait until every expected beat has come, then the pipeline drain time.
	task automatic drain_outputs();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_coefs.size() == 0);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Send one index beat; expectation is booked when it is accepted.
	// Valid stays high after the beat; the next send or a drain decides its level.
	task automatic send_index(input logic [IDX_W-1:0] idx, input bit typed,
		input logic [COEF_W-1:0] tc, input logic te);
		coef_beat_t e;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		sample_index <= idx;
		e = predict_coef(idx);
		if (typed && (e.coef !== tc || e.err !== te)) begin
			$error("table row %0d: expected %0d/%0b, predictor %0d/%0b", idx, tc, te,
				e.coef, e.err);
			fail_count++;
		end
		do @(posedge clk); while (in_stall);
		pending_coefs.push_back(e);
		beats_sent++;
	endtask

	// Window setting and index chosen at random; most indexes are in range.
	task automatic random_phase(input int count, input int sip, input int rsp);
		logic [12:0] sz, cen;
		int          r;
		send_idle_pct  = sip;
		recv_stall_pct = rsp;
		drain_outputs();
		r = $urandom_range(9);
		if (r == 0)
			sz = 13'd4096;
		else if (r == 1)
			sz = 13'($urandom_range(8191));
		else if (r < 4)
			sz = 13'($urandom_range(4096, 1));
		else
			sz = 13'($urandom_range(64, 1));
		if ($urandom_range(2) == 0)
			cen = 13'h1FFF - 13'($urandom_range(3));
		else if ($urandom_range(7) == 0)
			cen = 13'($urandom_range(8191));
		else
			cen = 13'($urandom_range((sz == 0 ? 1 : sz) - 1));
		write_reg(REG_SIZE, sz);
		write_reg(REG_CENTRE, cen);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0 || sz == 0)
				send_index(IDX_W'($urandom()), 1'b0, '0, 1'b0);
			else
				send_index(IDX_W'($urandom_range(sz > 4096 ? 4095 : sz - 1)), 1'b0,
					'0, 1'b0);
		end
	endtask

	// Directed rows: setting, index, and typed result where obvious.
	typedef struct {
		logic [12:0]       size;
		logic [12:0]       centre;
		logic [IDX_W-1:0]  idx;
		bit                typed;
		logic [COEF_W-1:0] coef;
		logic              err;
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		'{13'd256,  13'h1FFF, 12'd0,    1'b0, 16'd0,     1'b0},
		'{13'd256,  13'h1FFF, 12'd127,  1'b0, 16'd0,     1'b0},
		'{13'd256,  13'h1FFF, 12'd255,  1'b0, 16'd0,     1'b0},
		'{13'd256,  13'h1FFF, 12'd256,  1'b1, 16'd0,     1'b1},
		'{13'd256,  13'h1FFF, 12'd4095, 1'b1, 16'd0,     1'b1},
		'{13'd0,    13'h1FFF, 12'd0,    1'b1, 16'd0,     1'b1},
		'{13'd4097, 13'h1FFF, 12'd0,    1'b1, 16'd0,     1'b1},
		'{13'd8191, 13'h1000, 12'd5,    1'b1, 16'd0,     1'b1},
		'{13'd1,    13'h1FFF, 12'd0,    1'b1, 16'h8000,  1'b0},
		'{13'd7,    13'h1FFF, 12'd3,    1'b1, 16'h8000,  1'b0},
		'{13'd7,    13'h1FFF, 12'd6,    1'b0, 16'd0,     1'b0},
		'{13'd2,    13'h1FFF, 12'd1,    1'b0, 16'd0,     1'b0},
		'{13'd10,   13'd3,    12'd3,    1'b1, 16'h8000,  1'b0},
		'{13'd10,   13'd3,    12'd0,    1'b0, 16'd0,     1'b0},
		'{13'd10,   13'd3,    12'd9,    1'b0, 16'd0,     1'b0},
		'{13'd10,   13'd10,   12'd0,    1'b1, 16'd0,     1'b1},
		'{13'd10,   13'd0,    12'd0,    1'b1, 16'h8000,  1'b0},
		'{13'd10,   13'd9,    12'd9,    1'b1, 16'h8000,  1'b0},
		'{13'd4096, 13'd4095, 12'd4095, 1'b1, 16'h8000,  1'b0},
		'{13'd4096, 13'd4095, 12'd0,    1'b0, 16'd0,     1'b0},
		'{13'd4096, 13'h1FFF, 12'd2048, 1'b0, 16'd0,     1'b0},
		'{13'd4096, 13'h1FFF, 12'd2730, 1'b0, 16'd0,     1'b0},
		'{13'd4096, 13'd0,    12'd1365, 1'b0, 16'd0,     1'b0}
	};

	initial begin
		logic [12:0] cur_size, cur_centre;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		sample_index   = '0;
		out_stall      = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_SIZE;
		cfg_data       = '0;
		fail_count     = 0;
		cycle_count    = 0;
		beats_sent     = 0;
		beats_checked  = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		win_size       = SIZE_RESET;
		win_centre     = CENTRE_RESET;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		cur_size   = SIZE_RESET;
		cur_centre = CENTRE_RESET;

		// Directed rows; registers change only when the row's setting differs.
		foreach (dir_rows[n]) begin
			if (dir_rows[n].size != cur_size || dir_rows[n].centre != cur_centre) begin
				drain_outputs();
				write_reg(REG_SIZE, dir_rows[n].size);
				write_reg(REG_CENTRE, dir_rows[n].centre);
				cur_size   = dir_rows[n].size;
				cur_centre = dir_rows[n].centre;
			end
			send_index(dir_rows[n].idx, dir_rows[n].typed, dir_rows[n].coef,
				dir_rows[n].err);
		end

		// Random phases across the idling patterns, with a full pause midway.
		for (int p = 0; p < 40; p++) begin
			case (p % 5)
				0: random_phase(20, 0, 0);
				1: random_phase(20, 67, 0);
				2: random_phase(20, 0, 67);
				3: random_phase(20, 9, 9);
				default: random_phase(20, 0, 0);
			endcase
			if (p == 20)
				drain_outputs();
		end

		// Every bit of the index: full-size window, then idle out.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		drain_outputs();
		write_reg(REG_SIZE, 13'd4096);
		write_reg(REG_CENTRE, 13'h1FFF);
		send_index(12'hFFF, 1'b0, '0, 1'b0);
		send_index(12'hAAA, 1'b0, '0, 1'b0);
		send_index(12'h555, 1'b0, '0, 1'b0);
		drain_outputs();

		$display("Sent %0d index beats and checked %0d coefficients over the directed rows",
			beats_sent, beats_checked);
		$display("and 40 random settings: symmetric, asymmetric and invalid windows, with gaps.");
		if (fail_count == 0 && pending_coefs.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/hwc_pkg.sv
hw/rtl/hwc_front.sv
hw/rtl/hwc_queue.sv
hw/rtl/hwc_back.sv
hw/rtl/hann_window_coefficient_top.sv
tb/testbench.sv
